/* rtl/core/ntrp_pkg.sv */
// Shared types and constants for the target reply parser.
// Used by ntrp_frame, nfc_target_reply_parser_top and ntrp_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntrp_pkg;

   // Frame bytes
   localparam logic [7:0] START_LO   = 8'h00;
   localparam logic [7:0] START_HI   = 8'hFF;
   localparam logic [7:0] FRAME_TFI  = 8'hD5;
   localparam logic [7:0] LIST_CMD   = 8'h4A;
   localparam logic [7:0] LIST_REPLY = LIST_CMD + 8'h01;

   // Byte offsets from the FF of the start pair
   localparam int OFS_LEN     = 1;
   localparam int OFS_LCS     = 2;
   localparam int OFS_TFI     = 3;
   localparam int OFS_CODE    = 4;
   localparam int OFS_NTG     = 5;
   localparam int OFS_UID_LEN = 10;
   localparam int OFS_UID     = 11;
   localparam int HDR_SPAN    = 4;   // LEN, LCS, TFI received
   localparam int LEN_BASE    = 3;   // frame end = start + 3 + LEN
   localparam int MIN_LEN     = 3;   // TFI, code, target count

   localparam int UID_FIELD_BYTES = 10;

   // Result word layout, lowest bit first
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_ULEN_LSB   = 2;
   localparam int RSP_UIDLO_LSB  = 6;
   localparam int RSP_UIDHI_LSB  = 70;
   localparam int RSP_BITS       = 88;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NO_CARD   = 2'd1,
      ST_PROTO_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic       go;
      logic       last;
      logic [7:0] data;
   } step_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  uid_length;
      logic [63:0] uid_low;
      logic [15:0] uid_high;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/nfc_target_reply_parser_top.sv */
// Target reply parser: parses one list-passive-target reply per frame.
// req channel: one reply byte per transaction, tlast on the final byte of the window.
// rsp channel: one verdict per frame, sent after the tlast byte.
// The tlast byte passes the input register, then the parse logic into the result
// register, which holds the verdict.
// Throughput: one byte per cycle from the single-pass parse stage, unless stalled.
// The result register decouples the sides: bytes keep flowing while a verdict
// waits; only a tlast byte waits in the input register while the previous
// verdict is stalled on rsp_tready.
// Bytes past WINDOW_BYTES of a frame are accepted and ignored, but tlast there
// still closes the frame. The data checksum is not checked.
// Reset (synchronous) clears both stages and the frame state; req_tready is
// high in the first cycle after reset.
// Depends on ntrp_pkg and ntrp_frame.
`timescale 1ns / 1ps
`default_nettype none

module nfc_target_reply_parser_top #(
   parameter int WINDOW_BYTES  = 31,
   parameter int UID_MAX_BYTES = 10
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire         req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [87:0] rsp_tdata    // [1:0] status, [5:2] uid_length,
                                    // [69:6] uid_low, [85:70] uid_high, [87:86] zero
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       in_go;
   logic       req_take;
   logic       rsp_valid_ff, rsp_valid_in;
   ntrp_pkg::result_type rsp_ff;
   ntrp_pkg::step_type   step;
   ntrp_pkg::result_type result;

   assign in_go      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)   in_valid_in = 1'b1;
      else if (in_go) in_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_go && in_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready)     rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (in_go && in_last_ff) rsp_ff <= result;
   end

   assign step.go   = in_go;
   assign step.last = in_last_ff;
   assign step.data = in_data_ff;

   ntrp_frame #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .UID_MAX_BYTES (UID_MAX_BYTES)
   ) u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.uid_high, rsp_ff.uid_low,
                        rsp_ff.uid_length, rsp_ff.status};

endmodule

`default_nettype wire

/* rtl/core/ntrp_frame.sv */
// Per-frame parse state and final verdict for the target reply parser.
// Depends on ntrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntrp_frame #(
   parameter int WINDOW_BYTES  = 31,
   parameter int UID_MAX_BYTES = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   input  ntrp_pkg::step_type  step,
   output ntrp_pkg::result_type result
);

   localparam int CW = $clog2(WINDOW_BYTES + 1);
   localparam int SW = CW + 9;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    prev_ff, prev_in;
   logic          start_ff, start_in;
   logic [CW-1:0] sidx_ff, sidx_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    lcs_ff, lcs_in;
   logic [7:0]    tfi_ff, tfi_in;
   logic [7:0]    code_ff, code_in;
   logic [7:0]    ntg_ff, ntg_in;
   logic [7:0]    ulen_ff, ulen_in;
   logic [7:0]    uid_ff [UID_MAX_BYTES];
   logic [UID_MAX_BYTES-1:0] uid_wr;

   logic          in_window;
   logic [SW-1:0] byte_ofs;
   logic [SW-1:0] span_l, span_s;
   logic [7:0]    len_sum;
   ntrp_pkg::status_type status;
   logic [3:0]    uid_len;
   logic [8*ntrp_pkg::UID_FIELD_BYTES-1:0] uid_flat;

   assign in_window = count_ff < CW'(WINDOW_BYTES);
   assign byte_ofs  = SW'(count_ff) - SW'(sidx_ff);

   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      start_in = start_ff;
      sidx_in  = sidx_ff;
      len_in   = len_ff;
      lcs_in   = lcs_ff;
      tfi_in   = tfi_ff;
      code_in  = code_ff;
      ntg_in   = ntg_ff;
      ulen_in  = ulen_ff;
      uid_wr   = '0;
      if (step.go && in_window) begin
         count_in = count_ff + 1'b1;
         prev_in  = step.data;
         if (!start_ff) begin
            if (count_ff != '0 && prev_ff == ntrp_pkg::START_LO &&
                step.data == ntrp_pkg::START_HI) begin
               start_in = 1'b1;
               sidx_in  = count_ff;
            end
         end else if (count_ff > sidx_ff) begin
            if (byte_ofs == SW'(ntrp_pkg::OFS_LEN))     len_in  = step.data;
            if (byte_ofs == SW'(ntrp_pkg::OFS_LCS))     lcs_in  = step.data;
            if (byte_ofs == SW'(ntrp_pkg::OFS_TFI))     tfi_in  = step.data;
            if (byte_ofs == SW'(ntrp_pkg::OFS_CODE))    code_in = step.data;
            if (byte_ofs == SW'(ntrp_pkg::OFS_NTG))     ntg_in  = step.data;
            if (byte_ofs == SW'(ntrp_pkg::OFS_UID_LEN)) ulen_in = step.data;
            for (int k = 0; k < UID_MAX_BYTES; k++) begin
               if (byte_ofs == SW'(ntrp_pkg::OFS_UID + k)) uid_wr[k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.go && step.last)) begin
         count_ff <= '0;
         prev_ff  <= '0;
         start_ff <= 1'b0;
         sidx_ff  <= '0;
         len_ff   <= '0;
         lcs_ff   <= '0;
         tfi_ff   <= '0;
         code_ff  <= '0;
         ntg_ff   <= '0;
         ulen_ff  <= '0;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         start_ff <= start_in;
         sidx_ff  <= sidx_in;
         len_ff   <= len_in;
         lcs_ff   <= lcs_in;
         tfi_ff   <= tfi_in;
         code_ff  <= code_in;
         ntg_ff   <= ntg_in;
         ulen_ff  <= ulen_in;
      end
   end

   // UID bytes are only read back once all of them were received this frame
   always_ff @(posedge clock) begin
      for (int k = 0; k < UID_MAX_BYTES; k++) begin
         if (uid_wr[k]) uid_ff[k] <= step.data;
      end
   end

   // Verdict on the state as it stands after the current byte
   assign span_l  = SW'(count_in);
   assign span_s  = SW'(sidx_in);
   assign len_sum = len_in + lcs_in;

   always_comb begin
      status  = ntrp_pkg::ST_PROTO_ERR;
      uid_len = '0;
      if (!start_in) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (span_s + SW'(ntrp_pkg::HDR_SPAN) > span_l) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (len_sum != 8'h00) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (len_in == 8'h00 || tfi_in != ntrp_pkg::FRAME_TFI) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (span_s + SW'(ntrp_pkg::LEN_BASE) + SW'(len_in) > span_l) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (len_in < 8'(ntrp_pkg::MIN_LEN) || code_in != ntrp_pkg::LIST_REPLY) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (ntg_in == 8'h00) begin
         status = ntrp_pkg::ST_NO_CARD;
      end else if (span_s + SW'(ntrp_pkg::OFS_UID) > span_l) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else if (ulen_in == 8'h00 || ulen_in > 8'(UID_MAX_BYTES) ||
                   span_s + SW'(ntrp_pkg::OFS_UID) + SW'(ulen_in) > span_l) begin
         status = ntrp_pkg::ST_PROTO_ERR;
      end else begin
         status  = ntrp_pkg::ST_FOUND;
         uid_len = ulen_in[3:0];
      end
   end

   // uid_len is zero unless found, so this also blanks the UID on errors
   for (genvar k = 0; k < ntrp_pkg::UID_FIELD_BYTES; k++) begin : g_uid
      if (k < UID_MAX_BYTES) begin : g_used
         assign uid_flat[8*k +: 8] = (4'(k) < uid_len) ?
                                     (uid_wr[k] ? step.data : uid_ff[k]) : 8'h00;
      end else begin : g_unused
         assign uid_flat[8*k +: 8] = 8'h00;
      end
   end

   assign result.status     = status;
   assign result.uid_length = uid_len;
   assign result.uid_low    = uid_flat[63:0];
   assign result.uid_high   = uid_flat[79:64];

endmodule

`default_nettype wire

/* rtl/core/ntrp_checker.sv */
// Port-level checks for nfc_target_reply_parser_top, bound to the top level.
// Depends on ntrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntrp_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [87:0] rsp_tdata
);

   logic [1:0]  st;
   logic [3:0]  ulen;
   logic [79:0] uid;

   assign st   = rsp_tdata[ntrp_pkg::RSP_STATUS_LSB +: 2];
   assign ulen = rsp_tdata[ntrp_pkg::RSP_ULEN_LSB +: 4];
   assign uid  = rsp_tdata[ntrp_pkg::RSP_UIDLO_LSB +: 80];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("rsp_tvalid high or req_tready low after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (st == ntrp_pkg::ST_FOUND || st == ntrp_pkg::ST_NO_CARD ||
                      st == ntrp_pkg::ST_PROTO_ERR))
      else $error("illegal status code");

   a_miss_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st != ntrp_pkg::ST_FOUND |-> ulen == 4'd0 && uid == '0)
      else $error("uid data present without a found tag");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ntrp_pkg::ST_FOUND |->
         ulen != 4'd0 && ulen <= 4'(ntrp_pkg::UID_FIELD_BYTES) &&
         rsp_tdata[87:86] == 2'b00)
      else $error("found tag with bad uid length");

endmodule

bind nfc_target_reply_parser_top ntrp_checker u_ntrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
